[hw/rtl/pid_filtered_derivative_step_unit_defines.svh]
// Assertion macros for the PID filtered-derivative step unit.
// Included by the checker; depends on nothing else.
`ifndef PID_FILTERED_DERIVATIVE_STEP_UNIT_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked a fixed number of cycles later.
`define PFD_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[hw/rtl/pfd_pkg.sv]
// Shared types and constants of the PID filtered-derivative step unit.
// Used by the controller, the datapath and the top level; no dependencies.
package pfd_pkg;

    localparam int DATA_W     = 32;  // config registers, error sample, drive value
    localparam int CFG_IDX_W  = 3;
    localparam int DEN_W      = 48;  // 1 + N*Ts in Q16.16 stays below 2^48
    localparam int REC_W      = 17;  // 1/(1 + N*Ts) never exceeds 1.0
    localparam int MUL_A_W    = DATA_W + 1;
    localparam int MUL_B_W    = DATA_W + 2;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 52;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEG_GAIN    = 3'd1,
        CFG_DERIV_GAIN    = 3'd2,
        CFG_FILTER_COEF   = 3'd3,
        CFG_SAMPLE_PERIOD = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_IT,   // Ki * Ts
        MUL_NT,   // N * Ts
        MUL_KN,   // Kd * N
        MUL_P,    // Kp * e
        MUL_I,    // ih * (e + e1)
        MUL_DG,   // dg * (e - 2*e1 + e2)
        MUL_DR    // rec * D_prev
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_IT,
        S_PRE_NT,
        S_PRE_KN,
        S_DG_LOAD,
        S_DG_DIV,
        S_REC_LOAD,
        S_REC_DIV,
        S_REC_DONE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_DG,
        S_MUL_DR,
        S_D_ADD,
        S_D_SAT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     in_load;
        mul_sel_t mul_sel;
        logic     ih_load;
        logic     den_load;
        logic     div_load_kn;
        logic     div_load_rec;
        logic     div_step;
        logic     dg_store;
        logic     rec_store;
        logic     cfg_clean;
        logic     p_load;
        logic     i_add;
        logic     dg_load;
        logic     dr_add;
        logic     d_commit;
        logic     out_load;
    } pfd_cmd_t;

    typedef struct packed {
        logic cfg_dirty;
        logic out_free;
    } pfd_stat_t;

endpackage

[hw/rtl/pfd_ctrl.sv]
// Sequencer of the PID filtered-derivative step unit.
// Depends on pfd_pkg; drives the datapath through pfd_cmd_t.
module pfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_valid,
    input  pfd_pkg::pfd_stat_t stat,
    output logic             in_ready,
    output pfd_pkg::pfd_cmd_t  cmd
);
    import pfd_pkg::*;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   cnt_last;

    assign cnt_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    // derived coefficients are stale after any register write
                    state_next = stat.cfg_dirty ? S_PRE_IT : S_MUL_P;
                end
            end
            S_PRE_IT:   state_next = S_PRE_NT;
            S_PRE_NT:   state_next = S_PRE_KN;
            S_PRE_KN:   state_next = S_DG_LOAD;
            S_DG_LOAD:  state_next = S_DG_DIV;
            S_DG_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = S_REC_LOAD;
                end
            end
            S_REC_LOAD: state_next = S_REC_DIV;
            S_REC_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = S_REC_DONE;
                end
            end
            S_REC_DONE: state_next = S_MUL_P;
            S_MUL_P:    state_next = S_MUL_I;
            S_MUL_I:    state_next = S_MUL_DG;
            S_MUL_DG:   state_next = S_MUL_DR;
            S_MUL_DR:   state_next = S_D_ADD;
            S_D_ADD:    state_next = S_D_SAT;
            S_D_SAT:    state_next = S_OUT;
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_P;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = s_valid;
            end
            S_PRE_IT:   cmd.mul_sel = MUL_IT;
            S_PRE_NT:
            begin
                cmd.mul_sel = MUL_NT;
                cmd.ih_load = 1'b1;
            end
            S_PRE_KN:
            begin
                cmd.mul_sel  = MUL_KN;
                cmd.den_load = 1'b1;
            end
            S_DG_LOAD:  cmd.div_load_kn = 1'b1;
            S_DG_DIV:   cmd.div_step    = 1'b1;
            S_REC_LOAD:
            begin
                cmd.dg_store     = 1'b1;
                cmd.div_load_rec = 1'b1;
            end
            S_REC_DIV:  cmd.div_step = 1'b1;
            S_REC_DONE:
            begin
                cmd.rec_store = 1'b1;
                cmd.cfg_clean = 1'b1;
            end
            S_MUL_P:    cmd.mul_sel = MUL_P;
            S_MUL_I:
            begin
                cmd.mul_sel = MUL_I;
                cmd.p_load  = 1'b1;
            end
            S_MUL_DG:
            begin
                cmd.mul_sel = MUL_DG;
                cmd.i_add   = 1'b1;
            end
            S_MUL_DR:
            begin
                cmd.mul_sel = MUL_DR;
                cmd.dg_load = 1'b1;
            end
            S_D_ADD:    cmd.dr_add   = 1'b1;
            S_D_SAT:    cmd.d_commit = 1'b1;
            S_OUT:      cmd.out_load = stat.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

[hw/rtl/pfd_dpath.sv]
// Datapath of the PID filtered-derivative step unit: config registers,
// shared multiplier, radix-2 divider, accumulators and output register.
// Depends on pfd_pkg; commanded by pfd_ctrl.
module pfd_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfd_pkg::pfd_cmd_t             cmd,
    output pfd_pkg::pfd_stat_t            stat,
    input  logic                          cfg_wr_en,
    input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfd_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic [pfd_pkg::DATA_W-1:0]    in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pfd_pkg::DATA_W-1:0]    out_data
);
    import pfd_pkg::*;

    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if ((&top) || (~|top))
            return v[DATA_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    // configuration
    logic [DATA_W-1:0]          kp_reg, ki_reg, kd_reg, nf_reg, ts_reg;
    logic                       dirty_reg;

    // derived coefficients
    logic [DATA_W-1:0]          ih_reg, dg_reg;
    logic [DEN_W-1:0]           den_reg;
    logic [REC_W-1:0]           rec_reg;

    // divider
    logic [DEN_W-1:0]           rem_reg;
    logic [DATA_W-1:0]          quo_reg;
    logic                       ovf_reg;
    logic [DEN_W:0]             trial;
    logic                       trial_ge;

    // sample state
    logic signed [DATA_W-1:0]   e_reg, e1_reg, e2_reg, dprev_reg;

    // multiplier and accumulators
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-FRAC_W-1:0] qm;
    logic signed [ACC_W-1:0]    qm_ext;
    logic signed [ACC_W-1:0]    acc_reg, dsum_reg;
    logic signed [DATA_W-1:0]   dsat;
    logic signed [MUL_B_W-1:0]  e_x, e1_x, e2_x;

    logic [DATA_W-1:0]          out_data_reg;
    logic                       out_valid_reg;

    assign e_x  = MUL_B_W'(e_reg);
    assign e1_x = MUL_B_W'(e1_reg);
    assign e2_x = MUL_B_W'(e2_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_IT:
            begin
                mul_a = {1'b0, ki_reg};
                mul_b = {2'b00, ts_reg};
            end
            MUL_NT:
            begin
                mul_a = {1'b0, nf_reg};
                mul_b = {2'b00, ts_reg};
            end
            MUL_KN:
            begin
                mul_a = {1'b0, kd_reg};
                mul_b = {2'b00, nf_reg};
            end
            MUL_P:
            begin
                mul_a = {1'b0, kp_reg};
                mul_b = e_x;
            end
            MUL_I:
            begin
                mul_a = {1'b0, ih_reg};
                mul_b = e_x + e1_x;
            end
            MUL_DG:
            begin
                mul_a = {1'b0, dg_reg};
                mul_b = e_x - (e1_x <<< 1) + e2_x;
            end
            MUL_DR:
            begin
                mul_a = {{(MUL_A_W-REC_W){1'b0}}, rec_reg};
                mul_b = MUL_B_W'(dprev_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    // floor(c*y / 2^16) is the top of the exact product
    assign qm     = prod_reg[PROD_W-1:FRAC_W];
    assign qm_ext = ACC_W'(qm);
    assign dsat   = sat_s32(dsum_reg);

    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            nf_reg    <= '0;
            ts_reg    <= '0;
            dirty_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            dirty_reg <= 1'b1;
            case (cfg_index)
                CFG_PROP_GAIN:     kp_reg <= cfg_wdata;
                CFG_INTEG_GAIN:    ki_reg <= cfg_wdata;
                CFG_DERIV_GAIN:    kd_reg <= cfg_wdata;
                CFG_FILTER_COEF:   nf_reg <= cfg_wdata;
                CFG_SAMPLE_PERIOD: ts_reg <= cfg_wdata;
                default:           kp_reg <= kp_reg;
            endcase
        end
        else if (cmd.cfg_clean)
        begin
            dirty_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (cmd.in_load)
            e_reg <= in_data;
        if (cmd.ih_load)
        begin
            // Ki*Ts/2, saturated to 32 bits
            if (|prod_reg[2*DATA_W-1:DATA_W+17])
                ih_reg <= '1;
            else
                ih_reg <= prod_reg[DATA_W+16:17];
        end
        if (cmd.den_load)
            den_reg <= prod_reg[2*DATA_W-1:FRAC_W] + DEN_W'(1 << FRAC_W);
        if (cmd.div_load_kn)
        begin
            // top word at or above den means the quotient exceeds 32 bits
            rem_reg <= DEN_W'(prod_reg[2*DATA_W-1:DATA_W]);
            quo_reg <= prod_reg[DATA_W-1:0];
            ovf_reg <= (DEN_W'(prod_reg[2*DATA_W-1:DATA_W]) >= den_reg);
        end
        else if (cmd.div_load_rec)
        begin
            // dividend 2^32: top word one, low word zero
            rem_reg <= DEN_W'(1);
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            else
                rem_reg <= trial[DEN_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], trial_ge};
        end
        if (cmd.dg_store)
            dg_reg <= ovf_reg ? '1 : quo_reg;
        if (cmd.rec_store)
            rec_reg <= quo_reg[REC_W-1:0];
        if (cmd.p_load)
            acc_reg <= qm_ext;
        else if (cmd.i_add)
            acc_reg <= acc_reg + qm_ext;
        else if (cmd.d_commit)
            acc_reg <= acc_reg + ACC_W'(dsat);
        if (cmd.dg_load)
            dsum_reg <= qm_ext;
        else if (cmd.dr_add)
            dsum_reg <= dsum_reg + qm_ext;
        if (cmd.out_load)
            out_data_reg <= sat_s32(acc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg    <= '0;
            e2_reg    <= '0;
            dprev_reg <= '0;
        end
        else if (cmd.d_commit)
        begin
            // advance the error history and hold the saturated derivative
            dprev_reg <= dsat;
            e2_reg    <= e1_reg;
            e1_reg    <= e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.cfg_dirty = dirty_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

endmodule

[hw/rtl/pid_filtered_derivative_step_unit.sv]
// Top level of the PID filtered-derivative step unit.
// Depends on pfd_pkg, pfd_ctrl and pfd_dpath.
//
// Usage:
//   Each transfer on the s_axis channel carries one error sample (signed
//   Q16.16); the unit answers with exactly one drive value on m_axis.
//   Gains, filter coefficient and sample period are written through the
//   cfg port (index 0..4) while the unit is idle; other indexes are ignored.
//   The drive value is loaded into the output register after the steps
//   MUL_P, MUL_I, MUL_DG, MUL_DR, D_ADD and D_SAT; no new sample is taken
//   before that. The first sample after reset or any register write waits
//   while the derived coefficients Ki*Ts/2, Kd*N/(1+N*Ts) and 1/(1+N*Ts)
//   are recomputed: a shared 33x34 multiplier plus two 32-step divisions.
//   The per-sample path is bounded by the shared multiplier, used 4 times.
//   Reset clears the config registers, error history and derivative state.
//   A result waits in the output register while m_axis_tready is low; the
//   unit holds the finished result in its last step and takes no new sample
//   until that register frees.
module pid_filtered_derivative_step_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pfd_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] err_sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pfd_pkg::DATA_W-1:0]    m_axis_tdata,   // [31:0] drive_value
    input  logic                          cfg_wr_en,
    input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfd_pkg::DATA_W-1:0]    cfg_wdata
);
    import pfd_pkg::*;

    pfd_cmd_t  cmd;
    pfd_stat_t stat;

    pfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    pfd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

[hw/rtl/pfd_checker.sv]
// Port-level checks of the PID filtered-derivative step unit, bound to the top.
// Depends on pid_filtered_derivative_step_unit_defines.svh.
`include "pid_filtered_derivative_step_unit_defines.svh"

module pfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result must stay put
    `PFD_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // one sample in flight: busy for the whole computation
    `PFD_ASSERT_DLY(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, 6, !s_axis_tready, "input taken while computing")

    // an idle unit stays idle until a sample arrives
    `PFD_ASSERT_NXT(a_idle_hold, clk, rst_n, s_axis_tready && !s_axis_tvalid, s_axis_tready, "left idle without input")

    // a new result only comes out of the computing phase
    `PFD_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared while idle")

endmodule

bind pid_filtered_derivative_step_unit pfd_checker u_pfd_checker (.*);
